@@ rtl/rcolh_pkg.sv @@
// Shared constants, types and helper functions of the RGB color histogram.
`timescale 1ns / 1ps

package rcolh_pkg;

    // Bin geometry and counter width
    localparam int CHANNEL_BITS = 5;
    localparam int COUNT_BITS   = 24;
    localparam int BIN_BITS     = 3 * CHANNEL_BITS;
    localparam int NUM_BINS     = 1 << BIN_BITS;
    localparam int BIN_SHIFT    = 8 - CHANNEL_BITS;
    localparam int OUT_BITS     = 24;

    typedef logic [BIN_BITS-1:0]   t_bin;
    typedef logic [COUNT_BITS-1:0] t_count;

    localparam t_count             COUNT_MAX = '1;
    localparam logic [BIN_BITS:0]  SCAN_END  = (BIN_BITS + 1)'(NUM_BINS);
    localparam logic [31:0]        OUT_MAX   = 32'h00FF_FFFF;

    // Operation codes of the func field
    localparam logic [2:0] FN_ADD   = 3'd0;
    localparam logic [2:0] FN_QUERY = 3'd1;
    localparam logic [2:0] FN_START = 3'd2;
    localparam logic [2:0] FN_NEXT  = 3'd3;
    localparam logic [2:0] FN_CLEAR = 3'd4;

    // Classified command as it sits in the command queue
    typedef struct packed {
        logic [2:0] func;
        t_bin       bin;
    } t_cmd;

    // Head of the command queue, front to back
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_head;

    // Back to front status
    typedef struct packed {
        logic pop;
        logic init_busy;
    } t_back_stat;

    // One result item
    typedef struct packed {
        logic [7:0]          bin_red;
        logic [7:0]          bin_green;
        logic [7:0]          bin_blue;
        logic [OUT_BITS-1:0] count;
        logic                at_end;
    } t_result;

    // Bin index from the top bits of each component, red most significant
    function automatic t_bin bin_of(input logic [7:0] red, input logic [7:0] green,
                                    input logic [7:0] blue);
        return {red[7 -: CHANNEL_BITS], green[7 -: CHANNEL_BITS], blue[7 -: CHANNEL_BITS]};
    endfunction

    // Report of one bin: color back on the 8-bit scale, count clamped to the field
    function automatic t_result bin_result(input t_bin idx, input t_count cnt);
        logic [31:0] wide;
        t_result     res;
        wide          = 32'(cnt);
        res.bin_red   = 8'(idx[BIN_BITS-1 -: CHANNEL_BITS]) << BIN_SHIFT;
        res.bin_green = 8'(idx[2*CHANNEL_BITS-1 -: CHANNEL_BITS]) << BIN_SHIFT;
        res.bin_blue  = 8'(idx[CHANNEL_BITS-1:0]) << BIN_SHIFT;
        res.count     = (wide > OUT_MAX) ? OUT_MAX[OUT_BITS-1:0] : wide[OUT_BITS-1:0];
        res.at_end    = 1'b0;
        return res;
    endfunction

    // Report of an iteration that found nothing more
    function automatic t_result end_result();
        t_result res;
        res        = '0;
        res.at_end = 1'b1;
        return res;
    endfunction

endpackage

@@ rtl/rcolh_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rcolh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rcolh_front.sv @@
// Front end: takes items, classifies them and queues the commands for the engine.
`timescale 1ns / 1ps

module rcolh_front import rcolh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [2:0] i_func,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_full,
    input  t_back_stat i_stat,
    output t_cmd_head  o_head
);

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_cnt;

    logic       w_known;
    logic       w_wr;
    logic       w_rd;
    t_cmd       w_cmd;

    // Classify: unused codes are taken and dropped here
    assign w_known    = (i_func == FN_ADD) || (i_func == FN_QUERY) || (i_func == FN_START) ||
                        (i_func == FN_NEXT) || (i_func == FN_CLEAR);
    assign w_cmd.func = i_func;
    assign w_cmd.bin  = bin_of(i_red, i_green, i_blue);

    assign o_full = (r_cnt == 2'd2) || i_stat.init_busy;
    assign w_wr   = i_push && !o_full && w_known;
    assign w_rd   = i_stat.pop;

    // Queue pointers
    always_comb begin
        n_wr_ptr = w_wr ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_rd ? !r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + 2'(w_wr) - 2'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rd_ptr];

endmodule

@@ rtl/rcolh_back.sv @@
// Back end: bin count store, add/query/scan/clear sequencer and result register.
`timescale 1ns / 1ps

module rcolh_back import rcolh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd_head  i_head,
    output t_back_stat o_stat,
    input  logic       i_pop,
    output logic       o_empty,
    output t_result    o_result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADDW = 3'd1;
    localparam logic [2:0] ST_QRY  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_CLR  = 3'd4;

    logic [2:0]        r_state,     n_state;
    t_bin              r_cursor,    n_cursor;
    logic              r_live,      n_live;
    logic [BIN_BITS:0] r_scan_addr, n_scan_addr;
    logic              r_rd_pend,   n_rd_pend;
    t_bin              r_rd_idx,    n_rd_idx;
    t_bin              r_op_bin,    n_op_bin;
    t_bin              r_clr_addr,  n_clr_addr;
    logic              r_init,      n_init;
    logic              r_out_valid, n_out_valid;
    t_result           r_out,       n_out;

    logic   w_pop;
    logic   w_out_free;
    logic   w_we;
    t_bin   w_waddr;
    t_count w_wdata;
    logic   w_re;
    t_bin   w_raddr;
    t_count w_rdata;

    rcolh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // A result-producing command starts only when the result register frees up
    assign w_out_free = !r_out_valid || i_pop;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_live      = r_live;
        n_scan_addr = r_scan_addr;
        n_rd_pend   = r_rd_pend;
        n_rd_idx    = r_rd_idx;
        n_op_bin    = r_op_bin;
        n_clr_addr  = r_clr_addr;
        n_init      = r_init;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        w_pop       = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_op_bin;
        w_wdata     = t_count'(w_rdata + 1'b1);
        w_re        = 1'b0;
        w_raddr     = i_head.cmd.bin;

        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    unique case (i_head.cmd.func)
                        FN_ADD: begin
                            w_pop    = 1'b1;
                            w_re     = 1'b1;
                            n_op_bin = i_head.cmd.bin;
                            n_state  = ST_ADDW;
                        end
                        FN_QUERY: begin
                            if (w_out_free) begin
                                w_pop    = 1'b1;
                                w_re     = 1'b1;
                                n_op_bin = i_head.cmd.bin;
                                n_state  = ST_QRY;
                            end
                        end
                        FN_START: begin
                            if (w_out_free) begin
                                w_pop       = 1'b1;
                                n_scan_addr = '0;
                                n_rd_pend   = 1'b0;
                                n_state     = ST_SCAN;
                            end
                        end
                        FN_NEXT: begin
                            if (w_out_free) begin
                                w_pop = 1'b1;
                                if (!r_live) begin
                                    n_out       = end_result();
                                    n_out_valid = 1'b1;
                                end else begin
                                    n_scan_addr = {1'b0, r_cursor} + 1'b1;
                                    n_rd_pend   = 1'b0;
                                    n_state     = ST_SCAN;
                                end
                            end
                        end
                        FN_CLEAR: begin
                            w_pop      = 1'b1;
                            n_clr_addr = '0;
                            n_live     = 1'b0;
                            n_cursor   = '0;
                            n_state    = ST_CLR;
                        end
                        default: begin
                            w_pop = 1'b1;
                        end
                    endcase
                end
            end

            // Read data arrived: write back the saturating increment
            ST_ADDW: begin
                w_we    = (w_rdata != COUNT_MAX);
                n_state = ST_IDLE;
            end

            ST_QRY: begin
                n_out       = bin_result(r_op_bin, w_rdata);
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end

            // One bin read per cycle; check the bin read in the previous cycle
            ST_SCAN: begin
                priority if (r_rd_pend && (w_rdata != '0)) begin
                    n_out       = bin_result(r_rd_idx, w_rdata);
                    n_out_valid = 1'b1;
                    n_cursor    = r_rd_idx;
                    n_live      = 1'b1;
                    n_state     = ST_IDLE;
                end else if (r_scan_addr == SCAN_END) begin
                    n_out       = end_result();
                    n_out_valid = 1'b1;
                    n_live      = 1'b0;
                    n_state     = ST_IDLE;
                end else begin
                    w_re        = 1'b1;
                    w_raddr     = r_scan_addr[BIN_BITS-1:0];
                    n_rd_idx    = r_scan_addr[BIN_BITS-1:0];
                    n_rd_pend   = 1'b1;
                    n_scan_addr = r_scan_addr + 1'b1;
                end
            end

            // Zero one bin per cycle
            ST_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
                if (r_clr_addr == '1) begin
                    n_init  = 1'b0;
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state; reset starts a clearing pass over the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr_addr  <= '0;
            r_init      <= 1'b1;
            r_cursor    <= '0;
            r_live      <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_init      <= n_init;
            r_cursor    <= n_cursor;
            r_live      <= n_live;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_scan_addr <= n_scan_addr;
        r_rd_idx    <= n_rd_idx;
        r_op_bin    <= n_op_bin;
        r_out       <= n_out;
    end

    assign o_stat.pop       = w_pop;
    assign o_stat.init_busy = r_init;
    assign o_empty          = !r_out_valid;
    assign o_result         = r_out;

endmodule

@@ rtl/rgb_color_histogram.sv @@
// Top level of the RGB color histogram: front end, back end and result ports.
//
//  Channel  | Handshake         | Payload
//  ---------+-------------------+--------------------------------------------
//  command  | push / full       | i_func, i_red, i_green, i_blue
//  result   | empty / pop       | o_bin_red, o_bin_green, o_bin_blue,
//           |                   | o_count, o_at_end
//
// Engine work per item: add reads the count and writes it back, query reads it, next with no live
// iteration reports the end at once; start and next read one bin per cycle until a non-zero bin or
// the end of the store. Clear zeroes one bin per cycle, over all NUM_BINS bins.
// Reset runs the same zeroing pass over all NUM_BINS (32768) bins, with full held high.
// A two-item command queue takes items while the engine is busy; query, start and next
// wait in it while an untaken result holds the output register.
`timescale 1ns / 1ps

module rgb_color_histogram import rcolh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_bin_red,
    output logic [7:0]  o_bin_green,
    output logic [7:0]  o_bin_blue,
    output logic [23:0] o_count,
    output logic        o_at_end
);

    t_cmd_head  w_head;
    t_back_stat w_stat;
    t_result    w_result;

    rcolh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_func  (i_func),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_full  (full),
        .i_stat  (w_stat),
        .o_head  (w_head)
    );

    rcolh_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_stat   (w_stat),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (w_result)
    );

    // Result fields onto their ports
    assign o_bin_red   = w_result.bin_red;
    assign o_bin_green = w_result.bin_green;
    assign o_bin_blue  = w_result.bin_blue;
    assign o_count     = w_result.count;
    assign o_at_end    = w_result.at_end;

endmodule

@@ test/rgb_color_histogram_test.sv @@
// Self-checking testbench of the RGB color histogram: queue handshakes, mirrored bin store.
`timescale 1ns / 1ps

module rgb_color_histogram_test;
    import rcolh_pkg::*;

    // Run sizing
    localparam int RANDOM_ITEMS   = 1050;
    localparam int SCAN_BUDGET    = 420000;
    localparam int WATCHDOG_LIMIT = 10 * NUM_BINS;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AFTER     = 300;
    localparam int MAX_REPORTS    = 200;
    localparam int PALETTE_SIZE   = 8;

    // Codes the block ignores
    localparam logic [2:0] FN_SPARE_A = 3'd5;
    localparam logic [2:0] FN_SPARE_B = 3'd6;
    localparam logic [2:0] FN_SPARE_C = 3'd7;

    // Low component bits that fall inside one bin
    localparam logic [7:0] LOW_MASK = 8'((1 << BIN_SHIFT) - 1);

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [23:0] count;
        logic        at_end;
    } t_hist_report;

    localparam t_hist_report SCAN_DONE = '{8'd0, 8'd0, 8'd0, 24'd0, 1'b1};

    // Mirror of the bin store and the scan position; holds the reports still due
    class histogram_mirror;
        t_count       counts[NUM_BINS];
        int unsigned  cursor;
        bit           live;
        t_hist_report due_reports[$];
        int           errors;
        int           reports;

        function new();
            errors  = 0;
            reports = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (counts[i]) counts[i] = '0;
            cursor = 0;
            live   = 1'b0;
        endfunction

        function int unsigned bin_index(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            return ((32'(r) >> BIN_SHIFT) << (2 * CHANNEL_BITS))
                 | ((32'(g) >> BIN_SHIFT) << CHANNEL_BITS)
                 |  (32'(b) >> BIN_SHIFT);
        endfunction

        function t_hist_report bin_report(int unsigned idx);
            t_hist_report rep;
            int unsigned  mask;
            logic [31:0]  c;
            mask       = (1 << CHANNEL_BITS) - 1;
            c          = 32'(counts[idx]);
            rep.red    = 8'(((idx >> (2 * CHANNEL_BITS)) & mask) << BIN_SHIFT);
            rep.green  = 8'(((idx >> CHANNEL_BITS) & mask) << BIN_SHIFT);
            rep.blue   = 8'((idx & mask) << BIN_SHIFT);
            rep.count  = (c > OUT_MAX) ? OUT_MAX[23:0] : c[23:0];
            rep.at_end = 1'b0;
            return rep;
        endfunction

        // First non-zero bin at or above 'from', NUM_BINS when none
        function int unsigned first_nonzero(int unsigned from);
            for (int unsigned i = from; i < NUM_BINS; i++) begin
                if (counts[i] != '0) return i;
            end
            return NUM_BINS;
        endfunction

        function void run_scan(int unsigned from);
            int unsigned hit;
            hit = first_nonzero(from);
            if (hit < NUM_BINS) begin
                cursor = hit;
                live   = 1'b1;
                due_reports.push_back(bin_report(hit));
            end else begin
                live = 1'b0;
                due_reports.push_back(SCAN_DONE);
            end
        endfunction

        // Rough engine cycles an operation costs, used to keep the run short
        function int unsigned scan_cost(logic [2:0] f);
            case (f)
                FN_CLEAR: return NUM_BINS;
                FN_START: return first_nonzero(0) + 1;
                FN_NEXT:  return live ? first_nonzero(cursor + 1) - cursor : 0;
                default:  return 0;
            endcase
        endfunction

        function void take_command(logic [2:0] f, logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned idx;
            case (f)
                FN_ADD: begin
                    idx = bin_index(r, g, b);
                    if (counts[idx] != COUNT_MAX) counts[idx]++;
                end
                FN_QUERY: due_reports.push_back(bin_report(bin_index(r, g, b)));
                FN_START: run_scan(0);
                FN_NEXT: begin
                    if (live) run_scan(cursor + 1);
                    else due_reports.push_back(SCAN_DONE);
                end
                FN_CLEAR: wipe();
                default: ;
            endcase
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
                end
            end
        endfunction

        function void check_report(t_hist_report got);
            t_hist_report want;
            if (due_reports.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display({"%0t: result expected none, got red %0d green %0d blue %0d",
                              " count %0d end %0d"},
                             $time, got.red, got.green, got.blue, got.count, got.at_end);
                end
                return;
            end
            want = due_reports.pop_front();
            compare_field("bin_red", 32'(want.red), 32'(got.red));
            compare_field("bin_green", 32'(want.green), 32'(got.green));
            compare_field("bin_blue", 32'(want.blue), 32'(got.blue));
            compare_field("count", 32'(want.count), 32'(got.count));
            compare_field("at_end", 32'(want.at_end), 32'(got.at_end));
        endfunction

        function int pending();
            return due_reports.size();
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        full;
    logic [2:0]  i_func  = '0;
    logic [7:0]  i_red   = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_blue  = '0;
    logic        empty;
    logic        pop     = 1'b0;
    logic [7:0]  o_bin_red;
    logic [7:0]  o_bin_green;
    logic [7:0]  o_bin_blue;
    logic [23:0] o_count;
    logic        o_at_end;

    histogram_mirror mirror = new();

    int          accepted_items = 0;
    int          stall_cycles   = 0;
    int          burst_left     = 0;
    int          rand_items     = 0;
    int unsigned scan_budget    = 0;
    logic [23:0] palette[PALETTE_SIZE];

    rgb_color_histogram dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_func      (i_func),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .empty       (empty),
        .pop         (pop),
        .o_bin_red   (o_bin_red),
        .o_bin_green (o_bin_green),
        .o_bin_blue  (o_bin_blue),
        .o_count     (o_count),
        .o_at_end    (o_at_end)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sample both handshakes at the rising edge
    always @(posedge i_clk) begin : monitor
        t_hist_report got;
        if (i_rst_n) begin
            if (push && !full) begin
                mirror.take_command(i_func, i_red, i_green, i_blue);
                accepted_items++;
            end
            if (pop && !empty) begin
                got = '{o_bin_red, o_bin_green, o_bin_blue, o_count, o_at_end};
                mirror.check_report(got);
            end
        end
    end

    // Watchdog: too long without any item moving on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("** rgb_color_histogram: FAILED **");
            $finish;
        end
    end

    // Result side: segments of differing pop patterns, one long hold-off
    initial begin : receiver
        int         seg_left;
        int         mode;
        logic [7:0] pat;
        bit         held_long;
        seg_left  = 0;
        mode      = 0;
        pat       = '0;
        held_long = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_long && accepted_items >= HOLD_AFTER) begin
                held_long = 1'b1;
                pop <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(20, 200);
                    pat      = 8'($urandom);
                end
                seg_left--;
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom);
                    2: pop <= ($urandom_range(0, 3) == 0);
                    default: begin
                        pop <= pat[0];
                        pat = {pat[0], pat[7:1]};
                    end
                endcase
            end
        end
    end

    // Offer one item in the current burst; returns at the falling edge after acceptance
    task automatic offer(input logic [2:0] f, input logic [7:0] r, input logic [7:0] g,
                         input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        push    <= 1'b1;
        i_func  <= f;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold the input until every due report has been taken
    task automatic drain_results();
        push <= 1'b0;
        do @(negedge i_clk); while (mirror.pending() != 0);
    endtask

    // Random item: long scans and clears draw on a cycle budget, else become a query
    task automatic issue(input logic [2:0] f, input logic [23:0] rgb);
        logic [2:0]  op;
        int unsigned cost;
        op = f;
        if (op == FN_START || op == FN_NEXT || op == FN_CLEAR) begin
            cost = mirror.scan_cost(op);
            if (cost > scan_budget) op = FN_QUERY;
            else scan_budget -= cost;
        end
        if (op <= FN_CLEAR) rand_items++;
        offer(op, rgb[23:16], rgb[15:8], rgb[7:0]);
    endtask

    // Fully random color, or a palette color jittered within its bin
    function automatic logic [23:0] pick_color(input bit from_palette);
        logic [23:0] c;
        if (!from_palette) return 24'($urandom);
        c = palette[$urandom_range(0, PALETTE_SIZE - 1)];
        return (c & ~{3{LOW_MASK}}) | (24'($urandom) & {3{LOW_MASK}});
    endfunction

    initial begin : sender
        int kind;
        int n;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: scan corners, bin merging, iteration edges, ignored codes
        offer(FN_NEXT, 8'h00, 8'h00, 8'h00);         // next with no iteration
        offer(FN_START, 8'h00, 8'h00, 8'h00);        // start on an empty histogram
        offer(FN_ADD, 8'h00, 8'h00, 8'h00);
        offer(FN_ADD, 8'h07, 8'h07, 8'h07);          // same bin as black
        offer(FN_ADD, 8'hFF, 8'hFF, 8'hFF);
        offer(FN_ADD, 8'hF8, 8'hFF, 8'hFC);
        offer(FN_QUERY, 8'h00, 8'h00, 8'h00);
        offer(FN_QUERY, 8'hFF, 8'hFF, 8'hFF);
        offer(FN_QUERY, 8'h80, 8'h40, 8'h21);        // empty bin
        offer(FN_ADD, 8'h80, 8'h40, 8'h21);
        offer(FN_START, 8'h55, 8'hAA, 8'h55);
        offer(FN_NEXT, 8'hAA, 8'h55, 8'hAA);
        offer(FN_ADD, 8'hC8, 8'h0A, 8'h0A);          // ahead of the cursor: seen
        offer(FN_ADD, 8'h01, 8'h02, 8'h03);          // behind the cursor: skipped
        offer(FN_NEXT, 8'h00, 8'h00, 8'h00);
        offer(FN_NEXT, 8'h00, 8'h00, 8'h00);
        offer(FN_NEXT, 8'h00, 8'h00, 8'h00);         // runs off the end
        offer(FN_NEXT, 8'h00, 8'h00, 8'h00);         // next after the end
        offer(FN_SPARE_A, 8'hFF, 8'h00, 8'hAA);
        offer(FN_SPARE_B, 8'h55, 8'hFF, 8'h00);
        offer(FN_SPARE_C, 8'hAA, 8'h55, 8'hFF);
        offer(FN_START, 8'h00, 8'h00, 8'h00);
        offer(FN_CLEAR, 8'hFF, 8'hFF, 8'hFF);        // clear during an iteration
        offer(FN_NEXT, 8'h00, 8'h00, 8'h00);         // next after clear
        offer(FN_QUERY, 8'hFF, 8'hFF, 8'hFF);
        drain_results();

        // Random: pixel bursts, query bursts, iteration walks, noise
        foreach (palette[i]) palette[i] = 24'($urandom);
        scan_budget = SCAN_BUDGET;
        while (rand_items < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                n = $urandom_range(1, 30);
                repeat (n) issue(FN_ADD, pick_color(1'($urandom)));
            end else if (kind < 55) begin
                n = $urandom_range(1, 8);
                repeat (n) issue(FN_QUERY, pick_color($urandom_range(0, 3) != 0));
            end else if (kind < 80) begin
                issue(FN_START, pick_color(1'b0));
                n = $urandom_range(1, 40);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) issue(FN_ADD, pick_color(1'b1));
                    issue(FN_NEXT, pick_color(1'b0));
                end
            end else if (kind < 88) begin
                n = $urandom_range(1, 10);
                repeat (n) issue(3'($urandom), pick_color(1'b0));
            end else if (kind < 92) begin
                n = $urandom_range(1, 3);
                repeat (n) issue(FN_NEXT, pick_color(1'b0));
            end else if (kind < 96) begin
                issue(FN_CLEAR, pick_color(1'b0));
            end else begin
                drain_results();
            end
        end

        // Wind down: all reports in, then room for a trailing clear
        drain_results();
        repeat (NUM_BINS + 64) @(posedge i_clk);
        if (mirror.errors == 0) begin
            $display("** rgb_color_histogram: PASSED **");
        end else begin
            $display("** rgb_color_histogram: FAILED **");
        end
        $finish;
    end

endmodule
